FILE: src/embedding_sum_layernorm_core_assert.svh
`ifndef EMBEDDING_SUM_LAYERNORM_CORE_ASSERT_SVH
`define EMBEDDING_SUM_LAYERNORM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ESLN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ESLN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/esln_pkg.sv
package esln_pkg;

  localparam int DIM        = 64;
  localparam int VOCAB      = 1024;
  localparam int MAX_POS    = 512;
  localparam int EPS_Q20    = 10;
  localparam int POS_OFFSET = 2;
  localparam int SEQ_MAX    = 1023;

  // input and output field widths
  localparam int OP_W  = 3;
  localparam int ROW_W = 10;
  localparam int EL_W  = 6;
  localparam int VAL_W = 16;
  localparam int TOK_W = 10;
  localparam int SEQ_W = 10;

  localparam int VAL_MAX = 32767;
  localparam int VAL_MIN = -32768;

  localparam int DIM_AW   = $clog2(DIM);
  localparam int JC_W     = DIM_AW + 1;
  localparam int VROW_W   = $clog2(VOCAB);
  localparam int POSROW_W = $clog2(MAX_POS);
  localparam int WORD_AW  = $clog2(VOCAB * DIM);
  localparam int POS_AW   = $clog2(MAX_POS * DIM);

  // datapath widths
  localparam int X_W      = VAL_W + 2;            // sum of three Q5.10 entries
  localparam int SUM_W    = X_W + DIM_AW;         // running sum S
  localparam int SQT_W    = 2 * X_W - 2;          // one square, non-negative
  localparam int SQ_W     = SQT_W + DIM_AW;       // running sum of squares
  localparam int VD_W     = 2 * SUM_W + 1;        // variance numerator and W
  localparam int RAD_SH   = 16;
  localparam int SQ_STEPS = (VD_W + RAD_SH + 1) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 3;
  localparam int MAG_W    = X_W + DIM_AW;         // |DIM*x - S|
  localparam int D_W      = MAG_W + 1;
  localparam int DIV_SH   = 24;
  localparam int NUM_W    = MAG_W + DIV_SH + 1;
  localparam int Q_W      = 21;                   // |n| stays below sqrt(DIM) * 2^16 + 1
  localparam int DR_W     = SQ_STEPS + 1;
  localparam int N_W      = Q_W + 1;
  localparam int P_W      = N_W + VAL_W;
  localparam int RND_SH   = 16;
  localparam int RND_W    = P_W - RND_SH;
  localparam int Y_W      = RND_W + 2;
  localparam int CNT_W    = $clog2(SQ_STEPS);

  localparam int QDEPTH  = 2;
  localparam int QP_W    = $clog2(QDEPTH);
  localparam int QC_W    = $clog2(QDEPTH + 1);
  localparam int OQDEPTH = 2;
  localparam int OQP_W   = $clog2(OQDEPTH);
  localparam int OQC_W   = $clog2(OQDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WR_WORD  = 3'd0,
    OP_WR_POS   = 3'd1,
    OP_WR_TYPE  = 3'd2,
    OP_WR_GAMMA = 3'd3,
    OP_WR_BETA  = 3'd4,
    OP_ENCODE   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_VAR,
    ST_ROOT,
    ST_NREAD,
    ST_NLOAD,
    ST_DIV,
    ST_NMUL,
    ST_NOUT
  } state_t;

  typedef struct packed {
    op_t                        kind;
    logic [ROW_W-1:0]           row;
    logic [DIM_AW-1:0]          el;
    logic signed [VAL_W-1:0]    value;
    logic [VROW_W-1:0]          tok;
    logic [POSROW_W-1:0]        pos;
    logic                       clamped;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [EL_W-1:0]         index;
    logic                    last;
    logic                    sat;
    logic                    clamped;
  } res_t;

endpackage

FILE: src/esln_ram.sv
module esln_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/esln_front.sv
module esln_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [esln_pkg::OP_W-1:0]          in_operation,
  input  logic [esln_pkg::ROW_W-1:0]         in_table_row,
  input  logic [esln_pkg::EL_W-1:0]          in_element_index,
  input  logic signed [esln_pkg::VAL_W-1:0]  in_write_value,
  input  logic [esln_pkg::TOK_W-1:0]         in_token_id,
  input  logic                               in_first_of_sequence,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output esln_pkg::cmd_t                     cmd
);

  esln_pkg::cmd_t                  q_r [esln_pkg::QDEPTH];
  logic [esln_pkg::QP_W-1:0]       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [esln_pkg::QC_W-1:0]       cnt_r, cnt_nxt;
  logic [esln_pkg::SEQ_W-1:0]      seq_r, seq_nxt;

  esln_pkg::op_t                   op;
  esln_pkg::cmd_t                  ent;
  logic                            accept, keep, el_ok, take;
  logic [esln_pkg::SEQ_W-1:0]      base;
  logic [esln_pkg::ROW_W:0]        posf;
  logic                            clamp;

  assign op     = esln_pkg::op_t'(in_operation);
  assign full   = (cnt_r == esln_pkg::QC_W'(esln_pkg::QDEPTH));
  assign accept = push && !full;
  assign el_ok  = {1'b0, in_element_index} < (esln_pkg::EL_W + 1)'(esln_pkg::DIM);
  assign base   = in_first_of_sequence ? '0 : seq_r;
  assign posf   = (esln_pkg::ROW_W + 1)'(base) + (esln_pkg::ROW_W + 1)'(esln_pkg::POS_OFFSET);
  assign clamp  = posf > (esln_pkg::ROW_W + 1)'(esln_pkg::MAX_POS - 1);

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];
  assign take      = cmd_valid && cmd_ready;

  // classify: drop writes out of range and meaningless codes
  always_comb begin
    ent.kind    = op;
    ent.row     = in_table_row;
    ent.el      = esln_pkg::DIM_AW'(in_element_index);
    ent.value   = in_write_value;
    ent.tok     = ({1'b0, in_token_id} >= (esln_pkg::TOK_W + 1)'(esln_pkg::VOCAB)) ?
                  esln_pkg::VROW_W'(esln_pkg::VOCAB - 1) : esln_pkg::VROW_W'(in_token_id);
    ent.pos     = clamp ? esln_pkg::POSROW_W'(esln_pkg::MAX_POS - 1) :
                  esln_pkg::POSROW_W'(posf);
    ent.clamped = clamp;
    case (op)
      esln_pkg::OP_WR_WORD: begin
        keep = el_ok && ({1'b0, in_table_row} < (esln_pkg::ROW_W + 1)'(esln_pkg::VOCAB));
      end
      esln_pkg::OP_WR_POS: begin
        keep = el_ok && ({1'b0, in_table_row} < (esln_pkg::ROW_W + 1)'(esln_pkg::MAX_POS));
      end
      esln_pkg::OP_WR_TYPE, esln_pkg::OP_WR_GAMMA, esln_pkg::OP_WR_BETA: begin
        keep = el_ok;
      end
      esln_pkg::OP_ENCODE: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    seq_nxt  = seq_r;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (accept && op == esln_pkg::OP_ENCODE) begin
      seq_nxt = (base < esln_pkg::SEQ_W'(esln_pkg::SEQ_MAX)) ? base + 1'b1 : base;
    end
    if (accept && keep) begin
      wptr_nxt = (wptr_r == esln_pkg::QP_W'(esln_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (take) begin
      rptr_nxt = (rptr_r == esln_pkg::QP_W'(esln_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if ((accept && keep) && !take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(accept && keep) && take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      seq_r  <= seq_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q_r[wptr_r] <= ent;
    end
  end

endmodule

FILE: src/esln_back.sv
module esln_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  esln_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_pop,
  output esln_pkg::res_t res
);

  esln_pkg::state_t                    state_r, state_nxt;
  logic [esln_pkg::JC_W-1:0]           j_r, j_nxt;
  logic [esln_pkg::VROW_W-1:0]         tok_r, tok_nxt;
  logic [esln_pkg::POSROW_W-1:0]       pos_r, pos_nxt;
  logic                                clamp_r, clamp_nxt;

  logic                                v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic [esln_pkg::DIM_AW-1:0]         j1_r, j1_nxt, j2_r, j2_nxt;
  logic signed [esln_pkg::X_W-1:0]     x_r, x_nxt;
  logic [esln_pkg::SQT_W-1:0]          prod_r, prod_nxt;
  logic signed [esln_pkg::SUM_W-1:0]   s_r, s_nxt;
  logic [esln_pkg::SQ_W-1:0]           sq_r, sq_nxt;
  logic [2*esln_pkg::SUM_W-1:0]        ss_r, ss_nxt;

  logic [esln_pkg::RAD_W-1:0]          rad_r, rad_nxt;
  logic [esln_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [esln_pkg::SQ_STEPS-1:0]       root_r, root_nxt;
  logic [esln_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;

  logic                                neg_r, neg_nxt;
  logic [esln_pkg::DR_W-1:0]           drem_r, drem_nxt;
  logic [esln_pkg::Q_W-1:0]            dnum_r, dnum_nxt, quo_r, quo_nxt;
  logic signed [esln_pkg::P_W-1:0]     prod2_r, prod2_nxt;

  esln_pkg::res_t                      oq_r [esln_pkg::OQDEPTH];
  logic [esln_pkg::OQP_W-1:0]          owp_r, owp_nxt, orp_r, orp_nxt;
  logic [esln_pkg::OQC_W-1:0]          ocnt_r, ocnt_nxt;

  // memories
  logic                                word_we, pos_we, type_we, gamma_we, beta_we;
  logic [esln_pkg::WORD_AW-1:0]        word_waddr, word_raddr;
  logic [esln_pkg::POS_AW-1:0]         pos_waddr, pos_raddr;
  logic [esln_pkg::DIM_AW-1:0]         el_raddr;
  logic signed [esln_pkg::VAL_W-1:0]   word_q, pos_q, type_q, gamma_q, beta_q;
  logic signed [esln_pkg::X_W-1:0]     sum_q;

  // working values
  logic                                take, ofull, o_push, o_pop;
  esln_pkg::res_t                      o_ent;
  logic signed [2*esln_pkg::X_W-1:0]   sq_full;
  logic signed [2*esln_pkg::SUM_W-1:0] ss_full;
  logic [esln_pkg::VD_W-1:0]           vdiff, wv;
  logic [esln_pkg::REM_W-1:0]          rem_sh, trial;
  logic signed [esln_pkg::D_W-1:0]     dval;
  logic [esln_pkg::MAG_W-1:0]          mag;
  logic [esln_pkg::NUM_W-1:0]          num;
  logic [esln_pkg::DR_W-1:0]           dsh;
  logic                                dge;
  logic signed [esln_pkg::N_W-1:0]     nval;
  logic                                pneg;
  logic [esln_pkg::P_W-1:0]            pmag;
  logic [esln_pkg::RND_W-1:0]          rnd;
  logic signed [esln_pkg::Y_W-1:0]     ymag, ysum;

  assign cmd_ready = (state_r == esln_pkg::ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign ofull     = (ocnt_r == esln_pkg::OQC_W'(esln_pkg::OQDEPTH));
  assign res_valid = (ocnt_r != '0);
  assign res       = oq_r[orp_r];
  assign o_pop     = res_valid && res_pop;

  assign word_we  = take && cmd.kind == esln_pkg::OP_WR_WORD;
  assign pos_we   = take && cmd.kind == esln_pkg::OP_WR_POS;
  assign type_we  = take && cmd.kind == esln_pkg::OP_WR_TYPE;
  assign gamma_we = take && cmd.kind == esln_pkg::OP_WR_GAMMA;
  assign beta_we  = take && cmd.kind == esln_pkg::OP_WR_BETA;

  assign word_waddr = esln_pkg::WORD_AW'(cmd.row) * esln_pkg::WORD_AW'(esln_pkg::DIM) +
                      esln_pkg::WORD_AW'(cmd.el);
  assign pos_waddr  = esln_pkg::POS_AW'(cmd.row) * esln_pkg::POS_AW'(esln_pkg::DIM) +
                      esln_pkg::POS_AW'(cmd.el);
  assign el_raddr   = j_r[esln_pkg::DIM_AW-1:0];
  assign word_raddr = esln_pkg::WORD_AW'(tok_r) * esln_pkg::WORD_AW'(esln_pkg::DIM) +
                      esln_pkg::WORD_AW'(el_raddr);
  assign pos_raddr  = esln_pkg::POS_AW'(pos_r) * esln_pkg::POS_AW'(esln_pkg::DIM) +
                      esln_pkg::POS_AW'(el_raddr);

  esln_ram #(.DATA_W(esln_pkg::VAL_W), .DEPTH(esln_pkg::VOCAB * esln_pkg::DIM)) u_word (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(cmd.value),
    .raddr(word_raddr), .rdata(word_q)
  );
  esln_ram #(.DATA_W(esln_pkg::VAL_W), .DEPTH(esln_pkg::MAX_POS * esln_pkg::DIM)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(cmd.value),
    .raddr(pos_raddr), .rdata(pos_q)
  );
  esln_ram #(.DATA_W(esln_pkg::VAL_W), .DEPTH(esln_pkg::DIM)) u_type (
    .clk(clk), .we(type_we), .waddr(cmd.el), .wdata(cmd.value),
    .raddr(el_raddr), .rdata(type_q)
  );
  esln_ram #(.DATA_W(esln_pkg::VAL_W), .DEPTH(esln_pkg::DIM)) u_gamma (
    .clk(clk), .we(gamma_we), .waddr(cmd.el), .wdata(cmd.value),
    .raddr(el_raddr), .rdata(gamma_q)
  );
  esln_ram #(.DATA_W(esln_pkg::VAL_W), .DEPTH(esln_pkg::DIM)) u_beta (
    .clk(clk), .we(beta_we), .waddr(cmd.el), .wdata(cmd.value),
    .raddr(el_raddr), .rdata(beta_q)
  );
  esln_ram #(.DATA_W(esln_pkg::X_W), .DEPTH(esln_pkg::DIM)) u_sum (
    .clk(clk), .we(v2_r), .waddr(j2_r), .wdata(x_r),
    .raddr(el_raddr), .rdata(sum_q)
  );

  assign sq_full = x_r * x_r;
  assign ss_full = s_r * s_r;
  assign vdiff   = esln_pkg::VD_W'(sq_r) * esln_pkg::VD_W'(esln_pkg::DIM) -
                   esln_pkg::VD_W'(ss_r);
  assign wv      = (vdiff[esln_pkg::VD_W-1] ? '0 : vdiff) +
                   esln_pkg::VD_W'(esln_pkg::EPS_Q20 * esln_pkg::DIM * esln_pkg::DIM);
  assign rem_sh  = {rem_r[esln_pkg::REM_W-3:0], rad_r[esln_pkg::RAD_W-1 -: 2]};
  assign trial   = esln_pkg::REM_W'({root_r, 2'b01});
  assign dval    = esln_pkg::D_W'(sum_q) * esln_pkg::D_W'(esln_pkg::DIM) -
                   esln_pkg::D_W'(s_r);
  assign mag     = dval[esln_pkg::D_W-1] ? esln_pkg::MAG_W'(-dval) : esln_pkg::MAG_W'(dval);
  assign num     = (esln_pkg::NUM_W'(mag) << esln_pkg::DIV_SH) +
                   esln_pkg::NUM_W'(root_r >> 1);
  assign dsh     = {drem_r[esln_pkg::DR_W-2:0], dnum_r[esln_pkg::Q_W-1]};
  assign dge     = dsh >= esln_pkg::DR_W'(root_r);
  assign nval    = neg_r ? esln_pkg::N_W'(0) - esln_pkg::N_W'(quo_r) : esln_pkg::N_W'(quo_r);
  assign pneg    = prod2_r[esln_pkg::P_W-1];
  assign pmag    = pneg ? esln_pkg::P_W'(-prod2_r) : esln_pkg::P_W'(prod2_r);
  assign rnd     = esln_pkg::RND_W'((pmag + esln_pkg::P_W'(1 << (esln_pkg::RND_SH - 1)))
                   >> esln_pkg::RND_SH);
  assign ymag    = esln_pkg::Y_W'(rnd);
  assign ysum    = (pneg ? -ymag : ymag) + esln_pkg::Y_W'(beta_q);

  always_comb begin
    o_ent.index   = esln_pkg::EL_W'(el_raddr);
    o_ent.last    = (j_r == esln_pkg::JC_W'(esln_pkg::DIM - 1));
    o_ent.clamped = clamp_r;
    if (ysum > esln_pkg::Y_W'(esln_pkg::VAL_MAX)) begin
      o_ent.value = esln_pkg::VAL_W'(esln_pkg::VAL_MAX);
      o_ent.sat   = 1'b1;
    end else if (ysum < esln_pkg::Y_W'(esln_pkg::VAL_MIN)) begin
      o_ent.value = esln_pkg::VAL_W'(esln_pkg::VAL_MIN);
      o_ent.sat   = 1'b1;
    end else begin
      o_ent.value = esln_pkg::VAL_W'(ysum);
      o_ent.sat   = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    tok_nxt   = tok_r;
    pos_nxt   = pos_r;
    clamp_nxt = clamp_r;
    ss_nxt    = ss_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    drem_nxt  = drem_r;
    dnum_nxt  = dnum_r;
    quo_nxt   = quo_r;
    prod2_nxt = prod2_r;
    o_push    = 1'b0;

    // sum pass: read, add, accumulate
    v1_nxt   = (state_r == esln_pkg::ST_SUM) && (j_r < esln_pkg::JC_W'(esln_pkg::DIM));
    j1_nxt   = el_raddr;
    x_nxt    = esln_pkg::X_W'(word_q) + esln_pkg::X_W'(pos_q) + esln_pkg::X_W'(type_q);
    v2_nxt   = v1_r;
    j2_nxt   = j1_r;
    v3_nxt   = v2_r;
    prod_nxt = sq_full[esln_pkg::SQT_W-1:0];
    s_nxt    = v2_r ? s_r + esln_pkg::SUM_W'(x_r) : s_r;
    sq_nxt   = v3_r ? sq_r + esln_pkg::SQ_W'(prod_r) : sq_r;

    case (state_r)
      esln_pkg::ST_IDLE: begin
        if (take && cmd.kind == esln_pkg::OP_ENCODE) begin
          tok_nxt   = cmd.tok;
          pos_nxt   = cmd.pos;
          clamp_nxt = cmd.clamped;
          j_nxt     = '0;
          s_nxt     = '0;
          sq_nxt    = '0;
          state_nxt = esln_pkg::ST_SUM;
        end
      end
      esln_pkg::ST_SUM: begin
        if (j_r < esln_pkg::JC_W'(esln_pkg::DIM)) begin
          j_nxt = j_r + 1'b1;
        end else if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = esln_pkg::ST_SQ;
        end
      end
      esln_pkg::ST_SQ: begin
        ss_nxt    = ss_full;
        state_nxt = esln_pkg::ST_VAR;
      end
      esln_pkg::ST_VAR: begin
        rad_nxt   = esln_pkg::RAD_W'(wv) << esln_pkg::RAD_SH;
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = esln_pkg::ST_ROOT;
      end
      esln_pkg::ST_ROOT: begin
        // two radicand bits per step
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[esln_pkg::SQ_STEPS-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[esln_pkg::SQ_STEPS-2:0], 1'b0};
        end
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == esln_pkg::CNT_W'(esln_pkg::SQ_STEPS - 1)) begin
          j_nxt     = '0;
          state_nxt = esln_pkg::ST_NREAD;
        end
      end
      esln_pkg::ST_NREAD: begin
        state_nxt = esln_pkg::ST_NLOAD;
      end
      esln_pkg::ST_NLOAD: begin
        neg_nxt   = dval[esln_pkg::D_W-1];
        drem_nxt  = esln_pkg::DR_W'(num >> esln_pkg::Q_W);
        dnum_nxt  = num[esln_pkg::Q_W-1:0];
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = esln_pkg::ST_DIV;
      end
      esln_pkg::ST_DIV: begin
        // one quotient bit per step
        drem_nxt = dge ? dsh - esln_pkg::DR_W'(root_r) : dsh;
        quo_nxt  = {quo_r[esln_pkg::Q_W-2:0], dge};
        dnum_nxt = dnum_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == esln_pkg::CNT_W'(esln_pkg::Q_W - 1)) begin
          state_nxt = esln_pkg::ST_NMUL;
        end
      end
      esln_pkg::ST_NMUL: begin
        prod2_nxt = nval * gamma_q;
        state_nxt = esln_pkg::ST_NOUT;
      end
      esln_pkg::ST_NOUT: begin
        if (!ofull) begin
          o_push = 1'b1;
          if (o_ent.last) begin
            state_nxt = esln_pkg::ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = esln_pkg::ST_NREAD;
          end
        end
      end
      default: begin
        state_nxt = esln_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    owp_nxt  = o_push ? ((owp_r == esln_pkg::OQP_W'(esln_pkg::OQDEPTH - 1)) ? '0 : owp_r + 1'b1)
                      : owp_r;
    orp_nxt  = o_pop ? ((orp_r == esln_pkg::OQP_W'(esln_pkg::OQDEPTH - 1)) ? '0 : orp_r + 1'b1)
                     : orp_r;
    ocnt_nxt = ocnt_r;
    if (o_push && !o_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!o_push && o_pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esln_pkg::ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      owp_r   <= '0;
      orp_r   <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      owp_r   <= owp_nxt;
      orp_r   <= orp_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    tok_r   <= tok_nxt;
    pos_r   <= pos_nxt;
    clamp_r <= clamp_nxt;
    j1_r    <= j1_nxt;
    j2_r    <= j2_nxt;
    x_r     <= x_nxt;
    prod_r  <= prod_nxt;
    s_r     <= s_nxt;
    sq_r    <= sq_nxt;
    ss_r    <= ss_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    drem_r  <= drem_nxt;
    dnum_r  <= dnum_nxt;
    quo_r   <= quo_nxt;
    prod2_r <= prod2_nxt;
    if (o_push) begin
      oq_r[owp_r] <= o_ent;
    end
  end

endmodule

FILE: src/embedding_sum_layernorm_core.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        in_operation .. in_first_of_sequence
// result    out        empty / pop        out_element_value .. out_position_clamped
//
// An encode holds the back end until the last of its DIM results is queued; the
// divider is bit-serial, one quotient bit a cycle per element.
// Reset is synchronous and active low; it clears the sequence index, both
// queues and the sequencer. Tables hold no reset value.
// A full result queue holds the back end; a full command queue raises full.
`include "embedding_sum_layernorm_core_assert.svh"

module embedding_sum_layernorm_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               push,
  output logic                               full,
  input  logic [esln_pkg::OP_W-1:0]          in_operation,
  input  logic [esln_pkg::ROW_W-1:0]         in_table_row,
  input  logic [esln_pkg::EL_W-1:0]          in_element_index,
  input  logic signed [esln_pkg::VAL_W-1:0]  in_write_value,
  input  logic [esln_pkg::TOK_W-1:0]         in_token_id,
  input  logic                               in_first_of_sequence,
  // result channel
  output logic                               empty,
  input  logic                               pop,
  output logic signed [esln_pkg::VAL_W-1:0]  out_element_value,
  output logic [esln_pkg::EL_W-1:0]          out_index,
  output logic                               out_last,
  output logic                               out_saturated,
  output logic                               out_position_clamped
);

  // command transaction between the front and back ends
  logic           cmd_valid;
  logic           cmd_ready;
  esln_pkg::cmd_t cmd;
  logic           res_valid;
  esln_pkg::res_t res;

  // front end: classify, track the sequence index, queue commands
  esln_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_operation         (in_operation),
    .in_table_row         (in_table_row),
    .in_element_index     (in_element_index),
    .in_write_value       (in_write_value),
    .in_token_id          (in_token_id),
    .in_first_of_sequence (in_first_of_sequence),
    .cmd_valid            (cmd_valid),
    .cmd_ready            (cmd_ready),
    .cmd                  (cmd)
  );

  // back end: tables, three passes and the result queue
  esln_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty                = !res_valid;
  assign out_element_value    = res.value;
  assign out_index            = res.index;
  assign out_last             = res.last;
  assign out_saturated        = res.sat;
  assign out_position_clamped = res.clamped;

  // last mark only on the final element of a row
  `ESLN_ASSERT_NOW(a_last_index, !empty && out_last,
    out_index == esln_pkg::EL_W'(esln_pkg::DIM - 1), "last mark on wrong element")

  // an accepted encode reaches the command queue
  `ESLN_ASSERT_NEXT(a_encode_queued,
    push && !full && (in_operation == esln_pkg::OP_ENCODE), cmd_valid,
    "encode transaction lost by front end")

  // back end stays busy after starting an encode
  `ESLN_ASSERT_NEXT(a_encode_busy,
    cmd_valid && cmd_ready && (cmd.kind == esln_pkg::OP_ENCODE), !cmd_ready,
    "back end took a command during an encode")

endmodule
